// ===== hw/rtl/pan_tilt_servo_slew_controller_assert.svh =====
// Assertion macros for the pan/tilt servo slew controller.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef PAN_TILT_SERVO_SLEW_CONTROLLER_ASSERT_SVH
`define PAN_TILT_SERVO_SLEW_CONTROLLER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define PTSSC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define PTSSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/ptssc_pkg.sv =====
// Shared types, constants and helper functions for the pan/tilt servo slew controller.
// No dependencies.
package ptssc_pkg;

	localparam int PULSE_W    = 15;
	localparam int ANGLE_W    = 8;
	localparam int CELL_W     = 4;
	localparam int TRACK_W    = 17;
	localparam int STEP_W     = 8;
	localparam int TMO_W      = 16;
	localparam int AGE_W      = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int NUM_AXES   = 2;

	localparam int AX_PAN  = 0;
	localparam int AX_TILT = 1;

	localparam logic [AGE_W-1:0]   AGE_MAX  = '1;
	localparam logic [ANGLE_W-1:0] DEG_HOME = 8'd90;
	localparam logic [ANGLE_W-1:0] DEG_FULL = 8'd180;

	// (span * d + 90) never exceeds 32767 * 180 + 90, which fits in 23 bits
	localparam int                 SCALE_W     = 23;
	localparam logic [SCALE_W-1:0] SCALE_ROUND = 23'd90;
	// ceil(2^31 / 180): exact quotient for every dividend below 2^23
	localparam int                 RECIP_W     = 24;
	localparam int                 RECIP_SHIFT = 31;
	localparam logic [RECIP_W-1:0] RECIP_180   = 24'd11930465;

	localparam logic [PULSE_W-1:0] RST_MIN_US   = 15'd1000;
	localparam logic [PULSE_W-1:0] RST_MAX_US   = 15'd2000;
	localparam logic [PULSE_W-1:0] RST_PULSE_US = 15'd1500;
	localparam logic               RST_INVERT   = 1'b1;
	localparam logic [STEP_W-1:0]  RST_STEP     = 8'd3;
	localparam logic [TMO_W-1:0]   RST_TMO_MS   = 16'd1000;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_HOME  = 2'd1,
		OP_GRID  = 2'd2,
		OP_TRACK = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		CTRL_IDLE  = 2'd0,
		CTRL_GRID  = 2'd1,
		CTRL_TRACK = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PAN_MIN   = 3'd0,
		CFG_PAN_MAX   = 3'd1,
		CFG_TILT_MIN  = 3'd2,
		CFG_TILT_MAX  = 3'd3,
		CFG_PAN_INV   = 3'd4,
		CFG_TILT_INV  = 3'd5,
		CFG_SLEW_STEP = 3'd6,
		CFG_TIMEOUT   = 3'd7
	} cfg_idx_t;

	function automatic logic cell_valid(input logic [CELL_W-1:0] num);
		return (num >= 4'd1) && (num <= 4'd9);
	endfunction

	// column of the 3x3 grid sets pan
	function automatic logic [ANGLE_W-1:0] pan_of_cell(input logic [CELL_W-1:0] num);
		logic [ANGLE_W-1:0] deg;
		case (num) inside
			4'd1, 4'd4, 4'd7: deg = 8'd30;
			4'd3, 4'd6, 4'd9: deg = 8'd150;
			default:          deg = DEG_HOME;
		endcase
		return deg;
	endfunction

	// row of the 3x3 grid sets tilt
	function automatic logic [ANGLE_W-1:0] tilt_of_cell(input logic [CELL_W-1:0] num);
		logic [ANGLE_W-1:0] deg;
		case (num) inside
			4'd1, 4'd2, 4'd3: deg = 8'd120;
			4'd7, 4'd8, 4'd9: deg = 8'd60;
			default:          deg = DEG_HOME;
		endcase
		return deg;
	endfunction

	// step toward goal by at most step, never past it
	function automatic logic [ANGLE_W-1:0] slew_toward(input logic [ANGLE_W-1:0] cur,
			input logic [ANGLE_W-1:0] goal, input logic [STEP_W-1:0] step);
		logic [ANGLE_W-1:0] res;
		res = cur;
		if (cur < goal) begin
			res = ((goal - cur) > step) ? (cur + step) : goal;
		end else if (cur > goal) begin
			res = ((cur - goal) > step) ? (cur - step) : goal;
		end
		return res;
	endfunction

endpackage

// ===== hw/rtl/ptssc_in_if.sv =====
// Command channel of the pan/tilt servo slew controller: valid/ready plus one command item.
// Depends on ptssc_pkg.
interface ptssc_in_if;
	import ptssc_pkg::*;

	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic [CELL_W-1:0]  grid_cell;
	logic [TRACK_W-1:0] track_x;
	logic [TRACK_W-1:0] track_y;

	modport source (output valid, output opcode, output grid_cell, output track_x,
		output track_y, input ready);
	modport sink (input valid, input opcode, input grid_cell, input track_x,
		input track_y, output ready);
endinterface

// ===== hw/rtl/ptssc_out_if.sv =====
// Result channel of the pan/tilt servo slew controller: valid/ready plus one status item.
// Depends on ptssc_pkg.
interface ptssc_out_if;
	import ptssc_pkg::*;

	logic               valid;
	logic               ready;
	logic [PULSE_W-1:0] pan_pulse_us;
	logic [PULSE_W-1:0] tilt_pulse_us;
	logic [ANGLE_W-1:0] pan_angle;
	logic [ANGLE_W-1:0] tilt_angle;
	logic [1:0]         control_mode;
	logic               period_update;

	modport source (output valid, output pan_pulse_us, output tilt_pulse_us,
		output pan_angle, output tilt_angle, output control_mode, output period_update,
		input ready);
	modport sink (input valid, input pan_pulse_us, input tilt_pulse_us, input pan_angle,
		input tilt_angle, input control_mode, input period_update, output ready);
endinterface

// ===== hw/rtl/pan_tilt_servo_slew_controller.sv =====
// Pan/tilt servo aim controller: mode/goal/angle state, slew limiting, pulse width scaling.
// Depends on ptssc_pkg, ptssc_in_if, ptssc_out_if and the assertion macro header.
//
// Takes one command item per clock while the output accepts items, and returns exactly one status
// item per command, passing it through four registers: input register, state update, scale multiply,
// reciprocal divide. The rate is one item per cycle while the output accepts items; the
// divide by 180 in the pulse scaling is a multiply by a fixed reciprocal, split from the
// span multiply by a register. Every stage has its own valid bit, so commands keep flowing
// into empty stages while a finished status item waits on the output. A status item shows
// the pulse widths, angles and mode after its command; pulse widths only change on a tick
// that closes a control period.
module pan_tilt_servo_slew_controller #(
	parameter int CONTROL_PERIOD_TICKS = 20,
	parameter int FRAC_BITS            = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ptssc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [ptssc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	ptssc_in_if.sink                         cmd,
	ptssc_out_if.source                      rsp
);
	import ptssc_pkg::*;

	`include "pan_tilt_servo_slew_controller_assert.svh"

	localparam int CNT_W = $clog2(CONTROL_PERIOD_TICKS + 1);
	localparam int VW    = (FRAC_BITS + 1 > TRACK_W) ? (FRAC_BITS + 1) : TRACK_W;
	localparam int PW    = VW + ANGLE_W;
	localparam logic [VW-1:0]    FRAC_ONE  = VW'(1) << FRAC_BITS;
	localparam logic [PW-1:0]    FRAC_HALF = PW'(FRAC_ONE >> 1);
	localparam logic [PW-1:0]    FULL_P    = PW'(DEG_FULL);
	localparam logic [CNT_W-1:0] CNT_WRAP  = CNT_W'(CONTROL_PERIOD_TICKS);
	localparam int               PROD_W    = SCALE_W + RECIP_W;

	// configuration
	logic [PULSE_W-1:0] min_q [NUM_AXES];
	logic [PULSE_W-1:0] max_q [NUM_AXES];
	logic [NUM_AXES-1:0] inv_q;
	logic [STEP_W-1:0]  step_q;
	logic [TMO_W-1:0]   timeout_q;

	// controller state
	mode_t              mode_q;
	logic [ANGLE_W-1:0] now_q  [NUM_AXES];
	logic [ANGLE_W-1:0] goal_q [NUM_AXES];
	logic [CNT_W-1:0]   cnt_q;
	logic [AGE_W-1:0]   age_q;
	logic [PULSE_W-1:0] pulse_q [NUM_AXES];

	// pipeline
	logic               valid_s1, valid_s2, valid_s3, valid_s4;
	opcode_t            op_s1;
	logic [CELL_W-1:0]  cell_s1;
	logic [TRACK_W-1:0] tx_s1, ty_s1;

	mode_t              mode_s2, mode_s3, mode_s4;
	logic [ANGLE_W-1:0] ang_s2 [NUM_AXES];
	logic [ANGLE_W-1:0] ang_s3 [NUM_AXES];
	logic [ANGLE_W-1:0] ang_s4 [NUM_AXES];
	logic [ANGLE_W-1:0] d_s2   [NUM_AXES];
	logic [PULSE_W-1:0] span_s2 [NUM_AXES];
	logic [PULSE_W-1:0] lo_s2  [NUM_AXES];
	logic [PULSE_W-1:0] lo_s3  [NUM_AXES];
	logic [NUM_AXES-1:0] flat_s2, flat_s3;
	logic [SCALE_W-1:0] x_s3   [NUM_AXES];
	logic               did_s2, did_s3, did_s4;
	logic [PULSE_W-1:0] pulse_s4 [NUM_AXES];

	// pulse scaling datapath
	logic [ANGLE_W-1:0] d_n [NUM_AXES];
	logic [PROD_W-1:0]  quo_prod [NUM_AXES];
	logic [PULSE_W-1:0] pulse_s4_n [NUM_AXES];

	logic rdy1, rdy2, rdy3, rdy4;
	logic take1, move12, move23, move34;

	always_comb begin
		rdy4   = !valid_s4 || rsp.ready;
		rdy3   = !valid_s3 || rdy4;
		rdy2   = !valid_s2 || rdy3;
		rdy1   = !valid_s1 || rdy2;
		take1  = cmd.valid && rdy1;
		move12 = valid_s1 && rdy2;
		move23 = valid_s2 && rdy3;
		move34 = valid_s3 && rdy4;
	end

	assign cmd.ready = rdy1;

	// ---------------- state update from the registered command ----------------
	logic [VW-1:0]      vx, vy;
	logic [PW-1:0]      px, py;
	logic [ANGLE_W-1:0] track_pan, track_tilt;
	logic [AGE_W-1:0]   age_inc;
	logic [CNT_W-1:0]   cnt_inc;
	logic               wrap, stale;

	mode_t              mode_n;
	logic [ANGLE_W-1:0] now_n  [NUM_AXES];
	logic [ANGLE_W-1:0] goal_n [NUM_AXES];
	logic [CNT_W-1:0]   cnt_n;
	logic [AGE_W-1:0]   age_n;
	logic               did_n;
	logic               period_go;

	always_comb begin
		vx = VW'(tx_s1);
		vy = VW'(ty_s1);
		if (vx > FRAC_ONE) vx = FRAC_ONE;
		if (vy > FRAC_ONE) vy = FRAC_ONE;
		px = PW'(vx) * FULL_P + FRAC_HALF;
		py = PW'(vy) * FULL_P + FRAC_HALF;
		track_pan  = px[FRAC_BITS +: ANGLE_W];
		track_tilt = py[FRAC_BITS +: ANGLE_W];

		age_inc = (age_q == AGE_MAX) ? age_q : (age_q + 1'b1);
		cnt_inc = cnt_q + 1'b1;
		wrap    = cnt_inc >= CNT_WRAP;
		stale   = (mode_q == CTRL_TRACK) && (age_inc > AGE_W'(timeout_q));

		mode_n = mode_q;
		now_n  = now_q;
		goal_n = goal_q;
		cnt_n  = cnt_q;
		age_n  = age_q;
		did_n  = 1'b0;

		unique case (op_s1)
			OP_HOME: begin
				mode_n          = CTRL_IDLE;
				goal_n[AX_PAN]  = DEG_HOME;
				goal_n[AX_TILT] = DEG_HOME;
			end
			OP_GRID: begin
				if (cell_valid(cell_s1)) begin
					mode_n          = CTRL_GRID;
					goal_n[AX_PAN]  = pan_of_cell(cell_s1);
					goal_n[AX_TILT] = tilt_of_cell(cell_s1);
				end
			end
			OP_TRACK: begin
				mode_n          = CTRL_TRACK;
				goal_n[AX_PAN]  = track_pan;
				goal_n[AX_TILT] = track_tilt;
				age_n           = '0;
			end
			OP_TICK: begin
				age_n = age_inc;
				cnt_n = cnt_inc;
				if (wrap) begin
					cnt_n = '0;
					did_n = 1'b1;
					// lost track: fall back to home before slewing
					if (stale) begin
						mode_n          = CTRL_IDLE;
						goal_n[AX_PAN]  = DEG_HOME;
						goal_n[AX_TILT] = DEG_HOME;
					end
					for (int a = 0; a < NUM_AXES; a++) begin
						now_n[a] = slew_toward(now_q[a], goal_n[a], step_q);
					end
				end
			end
		endcase
		period_go = move12 && did_n;
	end

	// ---------------- control and state registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			mode_q    <= CTRL_IDLE;
			cnt_q     <= '0;
			age_q     <= '0;
			step_q    <= RST_STEP;
			timeout_q <= RST_TMO_MS;
			inv_q     <= {NUM_AXES{RST_INVERT}};
			for (int a = 0; a < NUM_AXES; a++) begin
				now_q[a]   <= DEG_HOME;
				goal_q[a]  <= DEG_HOME;
				min_q[a]   <= RST_MIN_US;
				max_q[a]   <= RST_MAX_US;
				pulse_q[a] <= RST_PULSE_US;
			end
		end else begin
			valid_s1 <= take1 || (valid_s1 && !rdy2);
			valid_s2 <= move12 || (valid_s2 && !rdy3);
			valid_s3 <= move23 || (valid_s3 && !rdy4);
			valid_s4 <= move34 || (valid_s4 && !rsp.ready);

			if (move12) begin
				mode_q <= mode_n;
				now_q  <= now_n;
				goal_q <= goal_n;
				cnt_q  <= cnt_n;
				age_q  <= age_n;
			end

			if (move34 && did_s3) begin
				pulse_q <= pulse_s4_n;
			end

			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_idx))
					CFG_PAN_MIN:   min_q[AX_PAN]  <= cfg_wdata[PULSE_W-1:0];
					CFG_PAN_MAX:   max_q[AX_PAN]  <= cfg_wdata[PULSE_W-1:0];
					CFG_TILT_MIN:  min_q[AX_TILT] <= cfg_wdata[PULSE_W-1:0];
					CFG_TILT_MAX:  max_q[AX_TILT] <= cfg_wdata[PULSE_W-1:0];
					CFG_PAN_INV:   inv_q[AX_PAN]  <= cfg_wdata[0];
					CFG_TILT_INV:  inv_q[AX_TILT] <= cfg_wdata[0];
					CFG_SLEW_STEP: step_q         <= cfg_wdata[STEP_W-1:0];
					CFG_TIMEOUT:   timeout_q      <= cfg_wdata[TMO_W-1:0];
				endcase
			end
		end
	end

	// ---------------- pulse scaling datapath ----------------
	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			d_n[a]      = inv_q[a] ? (DEG_FULL - now_n[a]) : now_n[a];
			quo_prod[a] = PROD_W'(x_s3[a]) * PROD_W'(RECIP_180);
			pulse_s4_n[a] = flat_s3[a] ? lo_s3[a]
				: (lo_s3[a] + quo_prod[a][RECIP_SHIFT +: PULSE_W]);
		end
	end

	always_ff @(posedge clk) begin
		if (take1) begin
			op_s1   <= opcode_t'(cmd.opcode);
			cell_s1 <= cmd.grid_cell;
			tx_s1   <= cmd.track_x;
			ty_s1   <= cmd.track_y;
		end
		if (move12) begin
			mode_s2 <= mode_n;
			did_s2  <= did_n;
			for (int a = 0; a < NUM_AXES; a++) begin
				ang_s2[a]  <= now_n[a];
				d_s2[a]    <= d_n[a];
				span_s2[a] <= max_q[a] - min_q[a];
				lo_s2[a]   <= min_q[a];
				flat_s2[a] <= max_q[a] < min_q[a];
			end
		end
		if (move23) begin
			mode_s3 <= mode_s2;
			did_s3  <= did_s2;
			flat_s3 <= flat_s2;
			for (int a = 0; a < NUM_AXES; a++) begin
				ang_s3[a] <= ang_s2[a];
				lo_s3[a]  <= lo_s2[a];
				x_s3[a]   <= SCALE_W'(span_s2[a]) * SCALE_W'(d_s2[a]) + SCALE_ROUND;
			end
		end
		if (move34) begin
			mode_s4 <= mode_s3;
			did_s4  <= did_s3;
			for (int a = 0; a < NUM_AXES; a++) begin
				ang_s4[a]   <= ang_s3[a];
				pulse_s4[a] <= did_s3 ? pulse_s4_n[a] : pulse_q[a];
			end
		end
	end

	assign rsp.valid         = valid_s4;
	assign rsp.pan_pulse_us  = pulse_s4[AX_PAN];
	assign rsp.tilt_pulse_us = pulse_s4[AX_TILT];
	assign rsp.pan_angle     = ang_s4[AX_PAN];
	assign rsp.tilt_angle    = ang_s4[AX_TILT];
	assign rsp.control_mode  = mode_s4;
	assign rsp.period_update = did_s4;

	// ---------------- assertions ----------------
	`PTSSC_ASSERT_NEXT(a_timeout_leaves_track, period_go,
		(mode_q != CTRL_TRACK) || (age_q <= AGE_W'(timeout_q)),
		"still tracking after the detection timeout")
	`PTSSC_ASSERT_NEXT(a_angles_move_only_on_period, !period_go,
		$stable(now_q[AX_PAN]) && $stable(now_q[AX_TILT]),
		"angle changed outside a control period")
	`PTSSC_ASSERT_NEXT(a_pan_slew_limit, period_go,
		((now_q[AX_PAN] >= $past(now_q[AX_PAN])) ? (now_q[AX_PAN] - $past(now_q[AX_PAN]))
		: ($past(now_q[AX_PAN]) - now_q[AX_PAN])) <= $past(step_q),
		"pan moved further than the slew step")
	`PTSSC_ASSERT_SAME(a_result_needs_item, valid_s4 && !valid_s3,
		rdy3, "stage three blocked while empty")

endmodule
